// File: hw/rtl/efcc_pkg.sv
// efcc_pkg: shared types and constants of the ethernet frame class counter
// used by efcc_rsp_if, efcc_parser and ethernet_frame_class_counter; depends on nothing
package efcc_pkg;

   // byte positions within an untagged frame
   localparam int unsigned POS_W = 6;
   localparam logic [POS_W-1:0] POS_MAX        = 6'd63;
   localparam logic [POS_W-1:0] POS_DEST_END   = 6'd6;
   localparam logic [POS_W-1:0] POS_ETYPE_HI   = 6'd12;
   localparam logic [POS_W-1:0] POS_ETYPE_LO   = 6'd13;
   localparam logic [POS_W-1:0] POS_PROTO      = 6'd23;
   localparam logic [POS_W-1:0] POS_SPORT_HI   = 6'd34;
   localparam logic [POS_W-1:0] POS_SPORT_LO   = 6'd35;
   localparam logic [POS_W-1:0] POS_DPORT_HI   = 6'd36;
   localparam logic [POS_W-1:0] POS_DPORT_LO   = 6'd37;

   // field values
   localparam logic [7:0]  BYTE_ONES    = 8'hFF;
   localparam logic [15:0] ETH_TYPE_MIN = 16'd1536;
   localparam logic [15:0] ETH_IP       = 16'h0800;
   localparam logic [15:0] ETH_ARP      = 16'h0806;
   localparam logic [7:0]  PROTO_ICMP   = 8'd1;
   localparam logic [7:0]  PROTO_TCP    = 8'd6;
   localparam logic [7:0]  PROTO_UDP    = 8'd17;
   localparam logic [15:0] PORT_DNS     = 16'd53;

   localparam int unsigned COUNT_W = 16;

   // class flags of one frame
   typedef struct packed {
      logic broadcast;
      logic ip;
      logic arp;
      logic icmp;
      logic tcp;
      logic dns;
   } class_flags_type;

   // running class counters
   typedef struct packed {
      logic [COUNT_W-1:0] broadcast;
      logic [COUNT_W-1:0] ip;
      logic [COUNT_W-1:0] arp;
      logic [COUNT_W-1:0] icmp;
      logic [COUNT_W-1:0] tcp;
      logic [COUNT_W-1:0] dns;
   } class_counts_type;

endpackage

// File: hw/rtl/efcc_if.sv
// efcc_req_if and efcc_rsp_if: valid/ready channels of the frame class counter
// depends on efcc_pkg for the counter width
interface efcc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] frame_byte;
   logic       last_byte;

   modport source (output valid, output frame_byte, output last_byte, input ready);
   modport sink (input valid, input frame_byte, input last_byte, output ready);
endinterface

interface efcc_rsp_if;
   logic                        valid;
   logic                        ready;
   logic                        was_broadcast;
   logic                        was_ip;
   logic                        was_arp;
   logic                        was_icmp;
   logic                        was_tcp;
   logic                        was_dns;
   logic [efcc_pkg::COUNT_W-1:0] broadcast_total;
   logic [efcc_pkg::COUNT_W-1:0] ip_total;
   logic [efcc_pkg::COUNT_W-1:0] arp_total;
   logic [efcc_pkg::COUNT_W-1:0] icmp_total;
   logic [efcc_pkg::COUNT_W-1:0] tcp_total;
   logic [efcc_pkg::COUNT_W-1:0] dns_total;

   modport source (
      output valid, output was_broadcast, output was_ip, output was_arp,
      output was_icmp, output was_tcp, output was_dns,
      output broadcast_total, output ip_total, output arp_total,
      output icmp_total, output tcp_total, output dns_total,
      input ready
   );
   modport sink (
      input valid, input was_broadcast, input was_ip, input was_arp,
      input was_icmp, input was_tcp, input was_dns,
      input broadcast_total, input ip_total, input arp_total,
      input icmp_total, input tcp_total, input dns_total,
      output ready
   );
endinterface

// File: hw/rtl/efcc_parser.sv
// efcc_parser: per-frame field capture and classification of the current byte
// depends on efcc_pkg for positions, field values and the flag struct
module efcc_parser (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      accept,
   input  logic [7:0]                frame_byte,
   input  logic                      last_byte,
   output efcc_pkg::class_flags_type flags
);

   logic [efcc_pkg::POS_W-1:0] pos_ff, pos_in;
   logic                       dest_ones_ff, dest_ones_in;
   logic [15:0]                etype_ff, etype_in;
   logic [7:0]                 proto_ff, proto_in;
   logic [15:0]                sport_ff, sport_in;
   logic [15:0]                dport_ff, dport_in;
   logic                       typed;

   // frame state as it stands once the current byte is taken in
   always_comb begin
      dest_ones_in = dest_ones_ff;
      etype_in     = etype_ff;
      proto_in     = proto_ff;
      sport_in     = sport_ff;
      dport_in     = dport_ff;
      if ((pos_ff < efcc_pkg::POS_DEST_END) && (frame_byte != efcc_pkg::BYTE_ONES)) begin
         dest_ones_in = 1'b0;
      end
      case (pos_ff)
         efcc_pkg::POS_ETYPE_HI: etype_in[15:8] = frame_byte;
         efcc_pkg::POS_ETYPE_LO: etype_in[7:0]  = frame_byte;
         efcc_pkg::POS_PROTO:    proto_in       = frame_byte;
         efcc_pkg::POS_SPORT_HI: sport_in[15:8] = frame_byte;
         efcc_pkg::POS_SPORT_LO: sport_in[7:0]  = frame_byte;
         efcc_pkg::POS_DPORT_HI: dport_in[15:8] = frame_byte;
         efcc_pkg::POS_DPORT_LO: dport_in[7:0]  = frame_byte;
         default: ;
      endcase
      pos_in = (pos_ff == efcc_pkg::POS_MAX) ? pos_ff : pos_ff + 6'd1;
   end

   // classification, meaningful on the last byte of a frame
   always_comb begin
      typed           = etype_in >= efcc_pkg::ETH_TYPE_MIN;
      flags.broadcast = dest_ones_in && (pos_in >= efcc_pkg::POS_DEST_END);
      flags.ip        = typed && (etype_in == efcc_pkg::ETH_IP);
      flags.arp       = typed && (etype_in == efcc_pkg::ETH_ARP);
      flags.icmp      = flags.ip && (proto_in == efcc_pkg::PROTO_ICMP);
      flags.tcp       = flags.ip && (proto_in == efcc_pkg::PROTO_TCP);
      flags.dns       = flags.ip && (proto_in == efcc_pkg::PROTO_UDP) &&
                        ((sport_in == efcc_pkg::PORT_DNS) || (dport_in == efcc_pkg::PORT_DNS));
   end

   // frame state, back to its start value on reset and after the last byte
   always_ff @(posedge clock) begin
      if (reset || (accept && last_byte)) begin
         pos_ff       <= '0;
         dest_ones_ff <= 1'b1;
         etype_ff     <= '0;
         proto_ff     <= '0;
         sport_ff     <= '0;
         dport_ff     <= '0;
      end else if (accept) begin
         pos_ff       <= pos_in;
         dest_ones_ff <= dest_ones_in;
         etype_ff     <= etype_in;
         proto_ff     <= proto_in;
         sport_ff     <= sport_in;
         dport_ff     <= dport_in;
      end
   end

endmodule

// File: hw/rtl/ethernet_frame_class_counter.sv
// ethernet_frame_class_counter: top level of the frame classifier and counters
// depends on efcc_pkg, efcc_req_if, efcc_rsp_if and efcc_parser
//
// Usage
//   req_if carries one frame byte per transaction, first byte of the
//   destination address first, with last_byte set on the final byte.
//   rsp_if carries one transaction per frame: the six class flags of the
//   frame and the six running 16-bit class totals, which include that frame.
//   Latency: the result is valid in the cycle after the last byte is taken.
//   Throughput, unless stalled: one byte per cycle, set by the single output
//   register; a new frame may start in the cycle after the last byte.
//   Stall: while a result waits and rsp_if.ready is low, req_if.ready is low;
//   when the result is taken, a new byte is accepted in that same cycle.
//   Reset (synchronous, active high) clears the frame state, the totals and
//   the result valid flag; the first byte may be offered in the next cycle.
module ethernet_frame_class_counter (
   input  logic         clock,
   input  logic         reset,
   efcc_req_if.sink     req_if,
   efcc_rsp_if.source   rsp_if
);

   logic                       req_fire;
   logic                       load;
   efcc_pkg::class_flags_type  flags_now;
   efcc_pkg::class_flags_type  flags_ff;
   efcc_pkg::class_counts_type counts_ff, counts_in;
   logic                       rsp_valid_ff, rsp_valid_in;

   // handshake on the input side
   assign req_if.ready = !rsp_valid_ff || rsp_if.ready;
   assign req_fire     = req_if.valid && req_if.ready;
   assign load         = req_fire && req_if.last_byte;

   // field capture and classification
   efcc_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .accept     (req_fire),
      .frame_byte (req_if.frame_byte),
      .last_byte  (req_if.last_byte),
      .flags      (flags_now)
   );

   // counter next values
   always_comb begin
      counts_in.broadcast = counts_ff.broadcast + {15'd0, flags_now.broadcast};
      counts_in.ip        = counts_ff.ip + {15'd0, flags_now.ip};
      counts_in.arp       = counts_ff.arp + {15'd0, flags_now.arp};
      counts_in.icmp      = counts_ff.icmp + {15'd0, flags_now.icmp};
      counts_in.tcp       = counts_ff.tcp + {15'd0, flags_now.tcp};
      counts_in.dns       = counts_ff.dns + {15'd0, flags_now.dns};
   end

   // output valid
   always_comb begin
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // counters and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         counts_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (load) begin
            counts_ff <= counts_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         flags_ff <= flags_now;
      end
   end

   // result transaction; totals change only when a new result is loaded
   assign rsp_if.valid           = rsp_valid_ff;
   assign rsp_if.was_broadcast   = flags_ff.broadcast;
   assign rsp_if.was_ip          = flags_ff.ip;
   assign rsp_if.was_arp         = flags_ff.arp;
   assign rsp_if.was_icmp        = flags_ff.icmp;
   assign rsp_if.was_tcp         = flags_ff.tcp;
   assign rsp_if.was_dns         = flags_ff.dns;
   assign rsp_if.broadcast_total = counts_ff.broadcast;
   assign rsp_if.ip_total        = counts_ff.ip;
   assign rsp_if.arp_total       = counts_ff.arp;
   assign rsp_if.icmp_total      = counts_ff.icmp;
   assign rsp_if.tcp_total       = counts_ff.tcp;
   assign rsp_if.dns_total       = counts_ff.dns;

`ifndef NO_ASSERTIONS
   // a last byte always leads to a result in the next cycle
   a_last_gives_result: assert property (@(posedge clock) disable iff (reset)
      load |=> rsp_valid_ff)
      else $error("no result after last byte");

   // a fresh result only ever follows a last byte
   a_result_from_last: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(load))
      else $error("result without last byte");

   // ip and arp are exclusive, and at most one ip sub-class is set
   a_class_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(flags_ff.ip && flags_ff.arp) &&
                       $onehot0({flags_ff.icmp, flags_ff.tcp, flags_ff.dns}))
      else $error("conflicting class flags");

   // ip sub-classes need the ip flag
   a_sub_class_ip: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (flags_ff.icmp || flags_ff.tcp || flags_ff.dns) |-> flags_ff.ip)
      else $error("ip sub-class without ip");

   // the ip total moves by exactly the ip flag of the loaded frame
   a_ip_count_step: assert property (@(posedge clock) disable iff (reset)
      load |=> counts_ff.ip == $past(counts_ff.ip) + {15'd0, flags_ff.ip})
      else $error("ip total out of step");
`endif

endmodule
